// ----- design/tte_pkg.sv -----
`default_nettype none

package tte_pkg;

  // Fixed field widths of the item, result and register set.
  localparam int DELAY_W  = 17;
  localparam int GAIN_W   = 7;
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 32;

  // Default depth of the echo buffer in words.
  localparam int TTE_RING_DEPTH = 65536;

  // Significant bits of an input sample; the rest are masked off.
  localparam int SAMPLE_BITS = 16;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                              : SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Gains are percentages and saturate at one hundred.
  localparam logic [GAIN_W-1:0] GAIN_MAX = 7'd100;

  // Unsigned 32-bit division by 100 as a multiply by a scaled reciprocal.
  localparam logic [31:0] RECIP_100   = 32'd1374389535;
  localparam int          RECIP_SHIFT = 37;

  // Configuration port address width: five registers at word addresses.
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_DELAY_A  = 3'd0,
    REG_GAIN_A   = 3'd1,
    REG_DELAY_B  = 3'd2,
    REG_GAIN_B   = 3'd3,
    REG_TWO_TAPS = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  // Register set as seen by the front end.
  typedef struct packed {
    logic [DELAY_W-1:0] delay_a;
    logic [GAIN_W-1:0]  gain_a;
    logic [DELAY_W-1:0] delay_b;
    logic [GAIN_W-1:0]  gain_b;
    logic               two_taps;
  } cfg_t;

  // Width of one queued command for a buffer address of aw bits.
  // Fields: emit, use_b, word, addr, slot_a, slot_b, gain_a, gain_b.
  function automatic int tte_cmd_width(input int aw);
    return 2 + SAMPLE_W + 3 * aw + 2 * GAIN_W;
  endfunction

  // Saturate a gain to one hundred percent.
  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_MAX) ? GAIN_MAX : g;
  endfunction

endpackage

`default_nettype wire

// ----- design/tte_if.sv -----
`default_nettype none

// Input channel: one sample word or silence tick per handshake.
interface tte_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  kind;
  logic [15:0] sample_in;

  modport source (output valid, output kind, output sample_in, input ready);
  modport sink   (input valid, input kind, input sample_in, output ready);
endinterface

// Output channel: one delayed word per handshake.
interface tte_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- design/tte_front.sv -----
`default_nettype none

module tte_front
  import tte_pkg::*;
#(
  parameter int RING_DEPTH = TTE_RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tte_in_if.sink     in_i,
  input  cfg_t       cfg_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output logic [tte_cmd_width($clog2(RING_DEPTH))-1:0] cmd_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(RING_DEPTH + 1);
  localparam int CW = (LW > DELAY_W) ? LW : DELAY_W;

  typedef struct packed {
    logic                emit;
    logic                use_b;
    logic [SAMPLE_W-1:0] word;
    logic [AW-1:0]       addr;
    logic [AW-1:0]       slot_a;
    logic [AW-1:0]       slot_b;
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_b;
  } cmd_t;

  // A delay of zero counts as one; delays saturate at the buffer depth.
  function automatic logic [LW-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
    logic [CW-1:0] dx;
    dx = CW'(d);
    if (d == '0) begin
      return LW'(1);
    end else if (dx > CW'(RING_DEPTH)) begin
      return LW'(RING_DEPTH);
    end else begin
      return LW'(dx);
    end
  endfunction

  // Slot that will be read delay items after base, wrapped at len.
  function automatic logic [AW-1:0] echo_slot(input logic [AW-1:0] base,
                                              input logic [LW-1:0] delay,
                                              input logic [LW-1:0] len);
    logic [LW:0] sum;
    sum = (LW+1)'(base) + (LW+1)'(delay);
    if (sum >= (LW+1)'(len)) begin
      sum = sum - (LW+1)'(len);
    end
    return AW'(sum);
  endfunction

  logic [LW-1:0] fill_count_q, fill_count_d;
  logic [AW-1:0] ring_pos_q, ring_pos_d;

  logic [LW-1:0] da, db, len;
  logic [AW-1:0] base, next_pos;
  logic [LW-1:0] pos_inc;
  logic          accept;
  cmd_t          cmd;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid & cmd_ready_i;
  assign cmd_o       = cmd;

  // Ring length follows the delays in use.
  always_comb begin
    da  = clamp_delay(cfg_i.delay_a);
    db  = clamp_delay(cfg_i.delay_b);
    len = (cfg_i.two_taps && (db > da)) ? db : da;
  end

  // Oldest slot, and where the ring goes after it.
  always_comb begin
    base     = (LW'(ring_pos_q) >= len) ? '0 : ring_pos_q;
    pos_inc  = LW'(base) + LW'(1);
    next_pos = (pos_inc >= len) ? '0 : AW'(pos_inc);
  end

  // Classify the item and build its command for the back end.
  always_comb begin
    cmd.emit   = (fill_count_q >= len);
    cmd.use_b  = cfg_i.two_taps;
    cmd.word   = (kind_e'(in_i.kind) == KIND_TICK) ? '0 : (in_i.sample_in & SAMPLE_MASK);
    cmd.addr   = cmd.emit ? base : AW'(fill_count_q);
    cmd.slot_a = echo_slot(base, da, len);
    cmd.slot_b = echo_slot(base, db, len);
    cmd.gain_a = clamp_gain(cfg_i.gain_a);
    cmd.gain_b = clamp_gain(cfg_i.gain_b);
  end

  // Fill count grows while filling; the ring position moves once full.
  always_comb begin
    fill_count_d = fill_count_q;
    ring_pos_d   = ring_pos_q;
    if (accept) begin
      if (cmd.emit) begin
        ring_pos_d = next_pos;
      end else begin
        fill_count_d = fill_count_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count_q <= '0;
      ring_pos_q   <= '0;
    end else begin
      fill_count_q <= fill_count_d;
      ring_pos_q   <= ring_pos_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/tte_fifo.sv -----
`default_nettype none

module tte_fifo
  import tte_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/tte_back.sv -----
`default_nettype none

module tte_back
  import tte_pkg::*;
#(
  parameter int RING_DEPTH = TTE_RING_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cmd_valid_i,
  output logic   cmd_ready_o,
  input  logic [tte_cmd_width($clog2(RING_DEPTH))-1:0] cmd_i,
  tte_out_if.source out_o
);

  localparam int AW = $clog2(RING_DEPTH);

  typedef struct packed {
    logic                emit;
    logic                use_b;
    logic [SAMPLE_W-1:0] word;
    logic [AW-1:0]       addr;
    logic [AW-1:0]       slot_a;
    logic [AW-1:0]       slot_b;
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_b;
  } cmd_t;

  typedef enum logic [5:0] {
    ST_FETCH = 6'b000001,
    ST_STORE = 6'b000010,
    ST_B_RD  = 6'b000100,
    ST_B_WR  = 6'b001000,
    ST_A_RD  = 6'b010000,
    ST_A_WR  = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;

  cmd_t              head, cmd_q;
  logic [DATA_W-1:0] mem_q [RING_DEPTH];
  logic [DATA_W-1:0] rdata_q, wdata;
  logic [AW-1:0]     raddr, waddr;
  logic              we, pop, out_free;

  logic [DATA_W-1:0] prod_a_q, prod_b_q, echo_q, div_src;
  logic [63:0]       recip_full;

  assign head        = cmd_t'(cmd_i);
  assign cmd_ready_o = pop;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // Sequencer: the read of the oldest word, its replacement, then one
  // read-modify-write of the buffer for each echo tap.
  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    we      = 1'b0;
    raddr   = head.addr;
    waddr   = cmd_q.addr;
    wdata   = DATA_W'(cmd_q.word);
    unique case (state_q)
      ST_FETCH: begin
        raddr = head.addr;
        if (cmd_valid_i) begin
          if (!head.emit) begin
            pop   = 1'b1;
            we    = 1'b1;
            waddr = head.addr;
            wdata = DATA_W'(head.word);
          end else if (out_free) begin
            pop     = 1'b1;
            state_d = ST_STORE;
          end
        end
      end
      ST_STORE: begin
        we      = 1'b1;
        state_d = cmd_q.use_b ? ST_B_RD : ST_A_RD;
      end
      ST_B_RD: begin
        raddr   = cmd_q.slot_b;
        state_d = ST_B_WR;
      end
      ST_B_WR: begin
        we      = 1'b1;
        waddr   = cmd_q.slot_b;
        wdata   = rdata_q + echo_q;
        state_d = ST_A_RD;
      end
      ST_A_RD: begin
        raddr   = cmd_q.slot_a;
        state_d = ST_A_WR;
      end
      ST_A_WR: begin
        we      = 1'b1;
        waddr   = cmd_q.slot_a;
        wdata   = rdata_q + echo_q;
        state_d = ST_FETCH;
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  // The output register is loaded with the word read out of the buffer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_STORE) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Echo buffer: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Division by 100 shares one reciprocal multiplier between both taps.
  assign div_src    = (state_q == ST_B_RD) ? prod_b_q : prod_a_q;
  assign recip_full = 64'(div_src) * 64'(RECIP_100);

  // Echo datapath: gain products, then the scaled echo.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= head;
    end
    if (state_q == ST_STORE) begin
      out_data_q <= rdata_q;
      prod_a_q   <= rdata_q * DATA_W'(cmd_q.gain_a);
      prod_b_q   <= rdata_q * DATA_W'(cmd_q.gain_b);
    end
    if ((state_q == ST_B_RD) || (state_q == ST_A_RD)) begin
      echo_q <= DATA_W'(recip_full >> RECIP_SHIFT);
    end
  end

  // The output register is always empty when a new word is read out.
  a_store_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |-> !out_valid_q)
    else $error("output register busy while a word is read out");

  // Every read-out word is offered at the next cycle.
  a_store_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STORE) |=> out_valid_q)
    else $error("read-out word not offered");

  // A result is offered only after a read-out.
  a_out_from_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_STORE))
    else $error("result offered without a read-out");

  // The last echo write always returns the sequencer to fetching.
  a_awr_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_WR) |=> (state_q == ST_FETCH))
    else $error("sequencer did not return after the last echo write");

endmodule

`default_nettype wire

// ----- design/two_tap_feedback_echo.sv -----
// Two-tap feedback echo over a ring buffer of RING_DEPTH 32-bit words.
// Input channel in_i: one word per handshake, either an audio sample or a
// silence tick that pushes zero so the echo tail drains. Output channel
// out_o: one delayed word, with the echoes added in, per handshake.
// The APB port writes the delays, gains and the second-tap enable; write it
// only while no item is in flight.
// The first L items (L is the larger delay in use) only fill the ring and
// give no result; every later item gives exactly one word.
// A filling item is stored by the back end as it is taken; an emitting
// item runs through the sequencer: it reads the oldest word, stores the new
// word, and does a read and a write for each echo tap before the back end
// takes the next item. With the back end free, an accepted item passes the
// command queue, the fetch and store states and the output register before
// its word is offered on out_o.
// A four-deep command queue keeps accepting items until it is full while
// the back end works or out_o is stalled; a stalled result holds its word,
// and the back end waits before reading out the next one.
// Reset clears the fill count, ring position, queue and output; the buffer
// contents are not cleared and need no clearing pass.
`default_nettype none

module two_tap_feedback_echo
  import tte_pkg::*;
#(
  parameter int RING_DEPTH = TTE_RING_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tte_in_if.sink                in_i,
  tte_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CMD_W = tte_cmd_width($clog2(RING_DEPTH));

  cfg_t       cfg_q, cfg_d;
  reg_idx_e   reg_idx;
  logic       cfg_write;

  logic             fe_valid, fe_ready, be_valid, be_ready;
  logic [CMD_W-1:0] fe_cmd, be_cmd;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (reg_idx)
        REG_DELAY_A:  cfg_d.delay_a  = pwdata[DELAY_W-1:0];
        REG_GAIN_A:   cfg_d.gain_a   = pwdata[GAIN_W-1:0];
        REG_DELAY_B:  cfg_d.delay_b  = pwdata[DELAY_W-1:0];
        REG_GAIN_B:   cfg_d.gain_b   = pwdata[GAIN_W-1:0];
        REG_TWO_TAPS: cfg_d.two_taps = pwdata[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_a  <= DELAY_W'(1);
      cfg_q.gain_a   <= '0;
      cfg_q.delay_b  <= DELAY_W'(1);
      cfg_q.gain_b   <= '0;
      cfg_q.two_taps <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_DELAY_A:  prdata = 32'(cfg_q.delay_a);
      REG_GAIN_A:   prdata = 32'(cfg_q.gain_a);
      REG_DELAY_B:  prdata = 32'(cfg_q.delay_b);
      REG_GAIN_B:   prdata = 32'(cfg_q.gain_b);
      REG_TWO_TAPS: prdata = 32'(cfg_q.two_taps);
      default:      prdata = '0;
    endcase
  end

  tte_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  tte_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_cmd)
  );

  tte_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_two_tap_feedback_echo.sv -----
`default_nettype none

module tb_two_tap_feedback_echo;
  timeunit 1ns;
  timeprecision 1ps;

  import tte_pkg::*;

  // Cycles allowed after the last expected word before touching registers.
  localparam int DRAIN_CYCLES = 40;
  // Cycles with no handshake at all before the run is called hung.
  localparam int STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  tte_in_if  in_if ();
  tte_out_if out_if ();

  two_tap_feedback_echo i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Echo predictor state: its own ring, pointers and register copy.
  logic [31:0] ring_mem [TTE_RING_DEPTH];
  int unsigned ring_pos_q;
  int unsigned fill_q;
  cfg_t        echo_cfg;

  // Words still owed by the block, oldest first.
  logic [31:0] echo_words_q [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatch_count;
  int unsigned n_samples;
  int unsigned n_ticks;
  int unsigned n_words;
  int unsigned n_settings;
  int unsigned quiet_cycles;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reset is held from the start and released once, at a falling edge.
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int unsigned sat_delay(input logic [DELAY_W-1:0] d);
    if (d == '0) return 1;
    if (d > TTE_RING_DEPTH) return TTE_RING_DEPTH;
    return 32'(d);
  endfunction

  function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
    return (g > 7'd100) ? 7'd100 : g;
  endfunction

  // Add one tap's echo into the slot that comes up dly words later.
  function automatic void mix_echo(input int unsigned base, input int unsigned len,
                                   input int unsigned dly, input logic [GAIN_W-1:0] g,
                                   input logic [31:0] src);
    int unsigned slot;
    logic [31:0] prod;
    slot = base + dly;
    if (slot >= len) slot -= len;
    prod = src * 32'(g);
    ring_mem[slot] = ring_mem[slot] + prod / 32'd100;
  endfunction

  // Advance the ring by one accepted word; returns 1 when a word comes out.
  function automatic bit ring_advance(input kind_e k, input logic [SAMPLE_W-1:0] s,
                                      output logic [31:0] word_o);
    int unsigned da;
    int unsigned db;
    int unsigned len;
    int unsigned base;
    logic [31:0] fresh;
    logic [31:0] oldest;
    da = sat_delay(echo_cfg.delay_a);
    db = sat_delay(echo_cfg.delay_b);
    len = da;
    if (echo_cfg.two_taps && db > len) len = db;
    fresh = (k == KIND_TICK) ? 32'd0 : 32'(s & SAMPLE_MASK);
    word_o = '0;
    // Still filling: store only.
    if (fill_q < len) begin
      ring_mem[fill_q] = fresh;
      fill_q++;
      return 1'b0;
    end
    if (ring_pos_q >= len) ring_pos_q = 0;
    base = ring_pos_q;
    oldest = ring_mem[base];
    ring_mem[base] = fresh;
    ring_pos_q = (base + 1 >= len) ? 0 : base + 1;
    if (echo_cfg.two_taps) mix_echo(base, len, db, sat_gain(echo_cfg.gain_b), oldest);
    mix_echo(base, len, da, sat_gain(echo_cfg.gain_a), oldest);
    word_o = oldest;
    return 1'b1;
  endfunction

  // Print at most a hundred mismatch lines, but count them all.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("[%0t] mismatch: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  // Predict on every accepted input word and check every accepted output word.
  always @(posedge clk_i) begin : echo_scoreboard
    logic [31:0] w;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (kind_e'(in_if.kind) == KIND_TICK) n_ticks++;
      else n_samples++;
      if (ring_advance(kind_e'(in_if.kind), in_if.sample_in, w)) echo_words_q.push_back(w);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_words++;
      if (echo_words_q.size() == 0) begin
        flag_mismatch("word with nothing expected", out_if.sample_out, 32'd0);
      end else begin
        w = echo_words_q.pop_front();
        if (out_if.sample_out !== w) flag_mismatch("sample_out", out_if.sample_out, w);
      end
    end
  end

  // Hang detection: any handshake or register access counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stalls at random.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Offer one word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(input kind_e k, input logic [SAMPLE_W-1:0] s);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random_word();
    kind_e k;
    logic [SAMPLE_W-1:0] s;
    k = ($urandom_range(99) < 15) ? KIND_TICK : KIND_SAMPLE;
    case ($urandom_range(19))
      0: s = 16'hFFFF;
      1: s = 16'h0000;
      default: s = 16'($urandom());
    endcase
    send_word(k, s);
  endtask

  // Drop valid, let every owed word come out, then give the back end time to settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (echo_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB write; the register copy follows at the access edge.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DELAY_A:  echo_cfg.delay_a  = value[DELAY_W-1:0];
      REG_GAIN_A:   echo_cfg.gain_a   = value[GAIN_W-1:0];
      REG_DELAY_B:  echo_cfg.delay_b  = value[DELAY_W-1:0];
      REG_GAIN_B:   echo_cfg.gain_b   = value[GAIN_W-1:0];
      REG_TWO_TAPS: echo_cfg.two_taps = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One APB read, compared with the register copy.
  task automatic check_reg(input reg_idx_e idx);
    logic [31:0] want;
    case (idx)
      REG_DELAY_A:  want = 32'(echo_cfg.delay_a);
      REG_GAIN_A:   want = 32'(echo_cfg.gain_a);
      REG_DELAY_B:  want = 32'(echo_cfg.delay_b);
      REG_GAIN_B:   want = 32'(echo_cfg.gain_b);
      REG_TWO_TAPS: want = 32'(echo_cfg.two_taps);
      default:      want = '0;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) flag_mismatch($sformatf("register %s", idx.name()), prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random junk above the field, so unused write data bits toggle too.
  function automatic logic [31:0] with_junk(input logic [31:0] field, input int width);
    logic [31:0] keep;
    keep = (32'd1 << width) - 32'd1;
    return ($urandom() & ~keep) | (field & keep);
  endfunction

  // Wait for the block to go quiet, write all five registers and read them back.
  task automatic apply_settings(input logic [DELAY_W-1:0] da, input logic [GAIN_W-1:0] ga,
                                input logic [DELAY_W-1:0] db, input logic [GAIN_W-1:0] gb,
                                input logic tt);
    wait_idle();
    write_reg(REG_DELAY_A, with_junk(32'(da), DELAY_W));
    write_reg(REG_GAIN_A, with_junk(32'(ga), GAIN_W));
    write_reg(REG_DELAY_B, with_junk(32'(db), DELAY_W));
    write_reg(REG_GAIN_B, with_junk(32'(gb), GAIN_W));
    write_reg(REG_TWO_TAPS, with_junk(32'(tt), 1));
    for (int i = 0; i < 5; i++) check_reg(reg_idx_e'(i));
    n_settings++;
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(9))
      0: return '0;
      1: return 17'd1;
      2: return 17'($urandom_range(25, 300));
      default: return 17'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return 7'd100;
      2: return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(1, 99));
    endcase
  endfunction

  // Reset values, then a one-word ring with no echo: each word comes back one item later.
  // A tick while filling stores zero.
  task automatic test_reset_values();
    for (int i = 0; i < 5; i++) check_reg(reg_idx_e'(i));
    send_word(KIND_TICK, 16'hFFFF);
    send_word(KIND_SAMPLE, 16'hFFFF);
    send_word(KIND_SAMPLE, 16'h0000);
    send_word(KIND_SAMPLE, 16'h8000);
    send_word(KIND_SAMPLE, 16'h0001);
    send_word(KIND_SAMPLE, 16'h5555);
    send_word(KIND_TICK, 16'hAAAA);
  endtask

  // Delay zero acts as one, gain above 100 saturates, and a tap as long as the
  // ring adds onto the word just stored.
  task automatic test_gain_and_delay_limits();
    apply_settings(17'd0, 7'h7F, 17'd3, 7'd100, 1'b1);
    repeat (3) send_word(KIND_SAMPLE, 16'hFFFF);
    send_word(KIND_TICK, 16'h0000);
    repeat (4) send_word(KIND_SAMPLE, 16'hFFFF);
  endtask

  // Growing the ring resumes filling; shrinking it wraps the read position.
  task automatic test_length_change();
    apply_settings(17'd8, 7'd50, 17'd3, 7'd25, 1'b0);
    for (int i = 0; i < 8; i++) send_word(KIND_SAMPLE, 16'(16'h1111 * i));
    apply_settings(17'd2, 7'd100, 17'd1, 7'd0, 1'b1);
    send_word(KIND_SAMPLE, 16'h7FFF);
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_SAMPLE, 16'h8001);
    send_word(KIND_TICK, 16'hFFFF);
  endtask

  // Random register settings, each followed by a burst of random words.
  task automatic test_random_echo(input int unsigned n_items);
    int unsigned sent;
    int unsigned chunk;
    sent = 0;
    while (sent < n_items) begin
      apply_settings(pick_delay(), pick_gain(), pick_delay(), pick_gain(),
                     1'($urandom_range(1)));
      chunk = $urandom_range(30, 70);
      repeat (chunk) send_random_word();
      sent += chunk;
    end
  endtask

  // An oversize delay saturates at the buffer depth, so its ring only fills;
  // a short ring afterwards counts as full and emits at once.
  task automatic test_oversize_delay();
    apply_settings(17'h1FFFF, 7'h7F, 17'(TTE_RING_DEPTH - 1), 7'd1, 1'b1);
    repeat (20) send_random_word();
    apply_settings(17'd12, 7'd60, 17'd5, 7'd30, 1'b1);
    repeat (20) send_random_word();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_SAMPLE;
    in_if.sample_in = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    quiet_cycles    = 0;
    mismatch_count  = 0;
    n_samples       = 0;
    n_ticks         = 0;
    n_words         = 0;
    n_settings      = 0;
    ring_pos_q      = 0;
    fill_q          = 0;
    echo_cfg         = '0;
    echo_cfg.delay_a = 17'd1;
    echo_cfg.delay_b = 17'd1;
    src_idle_pct    = 38;
    snk_idle_pct    = 45;

    @(posedge rst_ni);
    test_reset_values();
    test_gain_and_delay_limits();
    test_length_change();
    test_random_echo(220);
    src_idle_pct = 45;
    snk_idle_pct = 38;
    test_random_echo(220);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_echo(220);
    test_oversize_delay();
    wait_idle();

    $display("Sent %0d audio samples and %0d silence ticks under %0d register settings,",
             n_samples, n_ticks, n_settings);
    $display("with stalls on both sides and saturated delays and gains; %0d words checked.",
             n_words);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
